// ===== src/tpba_pkg.sv =====
package tpba_pkg;

	// default geometry of the two pools
	localparam int SMALL_BLOCKS_DEF       = 32;
	localparam int MEDIUM_BLOCKS_DEF      = 16;
	localparam int SMALL_BLOCK_BYTES_DEF  = 64;
	localparam int MEDIUM_BLOCK_BYTES_DEF = 256;

	// fixed field widths
	localparam int ADDR_W  = 32;
	localparam int IDX_W   = 5;
	localparam int CNT_W   = 6;
	localparam int SIZE_W  = 16;
	localparam int CFG_IDX_W = 8;

	// configuration register map
	localparam logic [CFG_IDX_W-1:0] CFG_SMALL_BASE  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_BASE = 8'd1;

	localparam logic [ADDR_W-1:0] SMALL_BASE_RST  = 32'd4096;
	localparam logic [ADDR_W-1:0] MEDIUM_BASE_RST = 32'd8192;

	typedef enum logic [1:0] {
		KIND_ALLOC_SIZE = 2'd0,
		KIND_ALLOC_POOL = 2'd1,
		KIND_FREE       = 2'd2,
		KIND_STATS      = 2'd3
	} tpba_kind_t;

	typedef enum logic [1:0] {
		OP_POP  = 2'd0,
		OP_PUSH = 2'd1,
		OP_PEEK = 2'd2
	} tpba_op_t;

	localparam logic POOL_SMALL  = 1'b0;
	localparam logic POOL_MEDIUM = 1'b1;

	// decoded request
	typedef struct packed {
		logic             pool_ok;
		logic             pool;
		tpba_op_t         op;
		logic             aligned;
		logic [IDX_W-1:0] free_idx;
	} tpba_dec_t;

	// command from the sequencer to one pool
	typedef struct packed {
		logic             commit;
		tpba_op_t         op;
		logic             aligned;
		logic [IDX_W-1:0] free_idx;
	} tpba_pool_cmd_t;

	// pool view after the step
	typedef struct packed {
		logic              ok;
		logic [IDX_W-1:0]  idx;
		logic [ADDR_W-1:0] granted;
		logic [CNT_W-1:0]  active;
		logic [CNT_W-1:0]  peak;
		logic [31:0]       mask;
		logic [31:0]       allocs;
		logic [31:0]       frees;
	} tpba_pool_res_t;

endpackage

// ===== src/tpba_link_mem.sv =====
module tpba_link_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int LW    = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [LW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [LW-1:0] wr_data
);

	logic [LW-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [LW-1:0] rd_q;
	logic [AW-1:0] rd_addr_q;
	logic          rd_vld_q;

	// unwritten entries link to the next block
	assign rd_data = rd_vld_q ? rd_q : (LW'(rd_addr_q) + LW'(1));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q      <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// the sequencer never reads and writes in the same cycle
	a_no_rd_wr: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("link table read and write collide");

endmodule

// ===== src/tpba_pool.sv =====
module tpba_pool #(
	parameter int BLOCKS      = 32,
	parameter int BLOCK_BYTES = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [31:0]            base,
	input  logic                   rd_en,
	input  tpba_pkg::tpba_pool_cmd_t cmd,
	output tpba_pkg::tpba_pool_res_t res
);
	import tpba_pkg::*;

	localparam int AW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
	localparam int LW = $clog2(BLOCKS + 1);

	logic [LW-1:0]     head_q, head_n;
	logic [BLOCKS-1:0] mask_q, mask_n;
	logic [LW-1:0]     active_q, active_n;
	logic [LW-1:0]     peak_q, peak_n;
	logic [31:0]       allocs_q, allocs_n;
	logic [31:0]       frees_q, frees_n;

	logic          head_ok;
	logic [AW-1:0] head_addr;
	logic [AW-1:0] free_addr;
	logic [LW-1:0] link_data;
	logic          ok;
	logic          wr_en;

	assign head_ok   = head_q < LW'(BLOCKS);
	assign head_addr = head_q[AW-1:0];
	assign free_addr = AW'(cmd.free_idx);

	tpba_link_mem #(
		.DEPTH (BLOCKS),
		.AW    (AW),
		.LW    (LW)
	) u_link (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en && head_ok),
		.rd_addr (head_addr),
		.rd_data (link_data),
		.wr_en   (wr_en),
		.wr_addr (free_addr),
		.wr_data (head_q)
	);

	always_comb begin
		head_n   = head_q;
		mask_n   = mask_q;
		active_n = active_q;
		peak_n   = peak_q;
		allocs_n = allocs_q;
		frees_n  = frees_q;
		ok       = 1'b0;
		res      = '0;
		case (cmd.op)
			OP_POP: begin
				ok = head_ok;
				if (head_ok) begin
					head_n   = link_data;
					mask_n   = mask_q | (BLOCKS'(1) << head_addr);
					active_n = active_q + LW'(1);
					if (active_n > peak_q) begin
						peak_n = active_n;
					end
					allocs_n    = allocs_q + 32'd1;
					res.idx     = IDX_W'(head_addr);
					res.granted = base + 32'(head_addr) * 32'(BLOCK_BYTES);
				end
			end
			OP_PUSH: begin
				ok = cmd.aligned && mask_q[free_addr];
				if (ok) begin
					mask_n   = mask_q & ~(BLOCKS'(1) << free_addr);
					head_n   = LW'(free_addr);
					active_n = (active_q == '0) ? active_q : active_q - LW'(1);
					frees_n  = frees_q + 32'd1;
					res.idx  = IDX_W'(free_addr);
				end
			end
			OP_PEEK: begin
				ok = 1'b1;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		res.ok     = ok;
		res.active = CNT_W'(active_n);
		res.peak   = CNT_W'(peak_n);
		res.mask   = 32'(mask_n);
		res.allocs = allocs_n;
		res.frees  = frees_n;
	end

	assign wr_en = cmd.commit && (cmd.op == OP_PUSH) && ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			mask_q   <= '0;
			active_q <= '0;
			peak_q   <= '0;
			allocs_q <= '0;
			frees_q  <= '0;
		end else if (cmd.commit) begin
			head_q   <= head_n;
			mask_q   <= mask_n;
			active_q <= active_n;
			peak_q   <= peak_n;
			allocs_q <= allocs_n;
			frees_q  <= frees_n;
		end
	end

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= LW'(BLOCKS))
		else $error("free list head out of range");

	a_active_mask: assert property (@(posedge clk) disable iff (!arst_n)
		active_q == LW'($countones(mask_q)))
		else $error("active count disagrees with allocation mask");

	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= active_q)
		else $error("peak below active count");

endmodule

// ===== src/tpba_decode.sv =====
module tpba_decode #(
	parameter int SMALL_BLOCKS       = 32,
	parameter int MEDIUM_BLOCKS      = 16,
	parameter int SMALL_BLOCK_BYTES  = 64,
	parameter int MEDIUM_BLOCK_BYTES = 256
) (
	input  logic [1:0]  kind,
	input  logic [15:0] request_size,
	input  logic [1:0]  pool_select,
	input  logic [31:0] block_address,
	input  logic [31:0] small_base,
	input  logic [31:0] medium_base,
	output tpba_pkg::tpba_dec_t dec
);
	import tpba_pkg::*;

	localparam logic [31:0] SMALL_TOTAL  = 32'(SMALL_BLOCKS * SMALL_BLOCK_BYTES);
	localparam logic [31:0] MEDIUM_TOTAL = 32'(MEDIUM_BLOCKS * MEDIUM_BLOCK_BYTES);

	logic [31:0]              small_off, medium_off;
	logic                     in_small, in_medium;
	logic [SMALL_BLOCKS-1:0]  small_hit;
	logic [MEDIUM_BLOCKS-1:0] medium_hit;
	logic [IDX_W-1:0]         small_idx, medium_idx;
	logic                     size_nz, size_small, size_medium;

	assign small_off  = block_address - small_base;
	assign medium_off = block_address - medium_base;
	assign in_small   = small_off < SMALL_TOTAL;
	assign in_medium  = medium_off < MEDIUM_TOTAL;

	// block boundaries matched in parallel: alignment and index in one go
	always_comb begin
		small_hit = '0;
		small_idx = '0;
		for (int i = 0; i < SMALL_BLOCKS; i++) begin
			small_hit[i] = small_off == 32'(i * SMALL_BLOCK_BYTES);
			if (small_hit[i]) begin
				small_idx = small_idx | IDX_W'(i);
			end
		end
	end

	always_comb begin
		medium_hit = '0;
		medium_idx = '0;
		for (int i = 0; i < MEDIUM_BLOCKS; i++) begin
			medium_hit[i] = medium_off == 32'(i * MEDIUM_BLOCK_BYTES);
			if (medium_hit[i]) begin
				medium_idx = medium_idx | IDX_W'(i);
			end
		end
	end

	assign size_nz     = request_size != '0;
	assign size_small  = {1'b0, request_size} <= 17'(SMALL_BLOCK_BYTES);
	assign size_medium = {1'b0, request_size} <= 17'(MEDIUM_BLOCK_BYTES);

	always_comb begin
		dec          = '0;
		dec.op       = OP_PEEK;
		dec.aligned  = in_small ? (|small_hit) : (|medium_hit);
		dec.free_idx = in_small ? small_idx : medium_idx;
		case (tpba_kind_t'(kind))
			KIND_ALLOC_SIZE: begin
				dec.op      = OP_POP;
				dec.pool_ok = size_nz && size_medium;
				dec.pool    = size_small ? POOL_SMALL : POOL_MEDIUM;
			end
			KIND_ALLOC_POOL: begin
				dec.op      = OP_POP;
				dec.pool_ok = pool_select == 2'd0 || pool_select == 2'd1;
				dec.pool    = pool_select[0];
			end
			KIND_FREE: begin
				dec.op      = OP_PUSH;
				dec.pool_ok = (block_address != '0) && (in_small || in_medium);
				dec.pool    = in_small ? POOL_SMALL : POOL_MEDIUM;
			end
			KIND_STATS: begin
				dec.op      = OP_PEEK;
				dec.pool_ok = pool_select == 2'd0 || pool_select == 2'd1;
				dec.pool    = pool_select[0];
			end
			default: begin
				dec.pool_ok = 1'b0;
			end
		endcase
	end

endmodule

// ===== src/two_pool_block_allocator_core.sv =====
// two-pool fixed block allocator
//
// requests arrive on req_valid/req_ready with kind, request_size, pool_select
// and block_address; each request yields exactly one response on
// rsp_valid/rsp_ready carrying status, the granted address, the pool touched
// and that pool's statistics after the request.
// the two pool base addresses are written through cfg_valid/cfg_ready with
// cfg_index 0 (small) or 1 (medium); other indexes are ignored. cfg_ready
// is always high, writes are meant to happen while no request is in flight.
// one request is in flight at a time: accept cycle, then an execute cycle in
// which the free-list link read issued at accept returns from the link table
// and the pool state commits. no new request is taken until the current one
// has executed; the response is registered when the request executes.
// when the receiver stalls, the response register holds and the next request
// is still accepted; its execute cycle waits until the response is taken.
// after reset both pools are fully free (each link table reads as a chain
// through flip-flop valid bits, no clearing pass), all counters are zero,
// and the bases are 4096 and 8192.
module two_pool_block_allocator_core #(
	parameter int SMALL_BLOCKS       = tpba_pkg::SMALL_BLOCKS_DEF,
	parameter int MEDIUM_BLOCKS      = tpba_pkg::MEDIUM_BLOCKS_DEF,
	parameter int SMALL_BLOCK_BYTES  = tpba_pkg::SMALL_BLOCK_BYTES_DEF,
	parameter int MEDIUM_BLOCK_BYTES = tpba_pkg::MEDIUM_BLOCK_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// request channel
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  kind,
	input  logic [15:0] request_size,
	input  logic [1:0]  pool_select,
	input  logic [31:0] block_address,
	// response channel
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic        status,
	output logic [31:0] granted_address,
	output logic        pool_used,
	output logic [4:0]  block_index,
	output logic [5:0]  active_blocks,
	output logic [5:0]  peak_blocks,
	output logic [31:0] allocated_bits,
	output logic [31:0] alloc_total,
	output logic [31:0] free_total
);
	import tpba_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;

	logic [31:0] small_base_q, medium_base_q;

	tpba_dec_t      dec, dec_s1;
	tpba_pool_cmd_t small_cmd, medium_cmd;
	tpba_pool_res_t small_res, medium_res, sel_res;

	logic accept;
	logic commit;
	logic rsp_valid_q;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_base_q  <= SMALL_BASE_RST;
			medium_base_q <= MEDIUM_BASE_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_SMALL_BASE) begin
				small_base_q <= cfg_data;
			end
			if (cfg_index == CFG_MEDIUM_BASE) begin
				medium_base_q <= cfg_data;
			end
		end
	end

	// request decode straight off the ports, captured on accept
	tpba_decode #(
		.SMALL_BLOCKS       (SMALL_BLOCKS),
		.MEDIUM_BLOCKS      (MEDIUM_BLOCKS),
		.SMALL_BLOCK_BYTES  (SMALL_BLOCK_BYTES),
		.MEDIUM_BLOCK_BYTES (MEDIUM_BLOCK_BYTES)
	) u_decode (
		.kind          (kind),
		.request_size  (request_size),
		.pool_select   (pool_select),
		.block_address (block_address),
		.small_base    (small_base_q),
		.medium_base   (medium_base_q),
		.dec           (dec)
	);

	assign req_ready = state_q == ST_IDLE;
	assign accept    = req_valid && req_ready;
	// execute only once the response register is free
	assign commit    = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s1 <= dec;
		end
	end

	always_comb begin
		small_cmd.commit    = commit && dec_s1.pool_ok && (dec_s1.pool == POOL_SMALL);
		small_cmd.op        = dec_s1.op;
		small_cmd.aligned   = dec_s1.aligned;
		small_cmd.free_idx  = dec_s1.free_idx;
		medium_cmd.commit   = commit && dec_s1.pool_ok && (dec_s1.pool == POOL_MEDIUM);
		medium_cmd.op       = dec_s1.op;
		medium_cmd.aligned  = dec_s1.aligned;
		medium_cmd.free_idx = dec_s1.free_idx;
	end

	// both pools issue their head link read on every accept while their free list is not empty
	tpba_pool #(
		.BLOCKS      (SMALL_BLOCKS),
		.BLOCK_BYTES (SMALL_BLOCK_BYTES)
	) u_small (
		.clk    (clk),
		.arst_n (arst_n),
		.base   (small_base_q),
		.rd_en  (accept),
		.cmd    (small_cmd),
		.res    (small_res)
	);

	tpba_pool #(
		.BLOCKS      (MEDIUM_BLOCKS),
		.BLOCK_BYTES (MEDIUM_BLOCK_BYTES)
	) u_medium (
		.clk    (clk),
		.arst_n (arst_n),
		.base   (medium_base_q),
		.rd_en  (accept),
		.cmd    (medium_cmd),
		.res    (medium_res)
	);

	assign sel_res = (dec_s1.pool == POOL_MEDIUM) ? medium_res : small_res;

	// sequencer and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			rsp_valid_q     <= 1'b0;
			status          <= 1'b0;
			granted_address <= '0;
			pool_used       <= 1'b0;
			block_index     <= '0;
			active_blocks   <= '0;
			peak_blocks     <= '0;
			allocated_bits  <= '0;
			alloc_total     <= '0;
			free_total      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (rsp_valid_q && rsp_ready) begin
						rsp_valid_q <= 1'b0;
					end
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (commit) begin
						state_q     <= ST_IDLE;
						rsp_valid_q <= 1'b1;
						if (dec_s1.pool_ok) begin
							status          <= !sel_res.ok;
							granted_address <= sel_res.granted;
							pool_used       <= dec_s1.pool;
							block_index     <= sel_res.idx;
							active_blocks   <= sel_res.active;
							peak_blocks     <= sel_res.peak;
							allocated_bits  <= sel_res.mask;
							alloc_total     <= sel_res.allocs;
							free_total      <= sel_res.frees;
						end else begin
							// no pool touched
							status          <= 1'b1;
							granted_address <= '0;
							pool_used       <= 1'b0;
							block_index     <= '0;
							active_blocks   <= '0;
							peak_blocks     <= '0;
							allocated_bits  <= '0;
							alloc_total     <= '0;
							free_total      <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;

	a_exec_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && rsp_valid_q && !rsp_ready) |=> state_q == ST_EXEC)
		else $error("request executed over an untaken response");

	a_one_pool: assert property (@(posedge clk) disable iff (!arst_n)
		!(small_cmd.commit && medium_cmd.commit))
		else $error("both pools committed in one cycle");

endmodule

// ===== dv/tpba_response_checker.sv =====
module tpba_response_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        req_valid,
	input  logic        req_ready,
	input  logic [1:0]  kind,
	input  logic [15:0] request_size,
	input  logic [1:0]  pool_select,
	input  logic [31:0] block_address,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  logic        status,
	input  logic [31:0] granted_address,
	input  logic        pool_used,
	input  logic [4:0]  block_index,
	input  logic [5:0]  active_blocks,
	input  logic [5:0]  peak_blocks,
	input  logic [31:0] allocated_bits,
	input  logic [31:0] alloc_total,
	input  logic [31:0] free_total,
	output int          mismatches,
	output int          outstanding
);
	import tpba_pkg::*;

	localparam logic [31:0] SMALL_SPAN  = SMALL_BLOCKS_DEF * SMALL_BLOCK_BYTES_DEF;
	localparam logic [31:0] MEDIUM_SPAN = MEDIUM_BLOCKS_DEF * MEDIUM_BLOCK_BYTES_DEF;

	typedef struct packed {
		logic              status;
		logic [ADDR_W-1:0] granted;
		logic              pool;
		logic [IDX_W-1:0]  idx;
		logic [CNT_W-1:0]  active;
		logic [CNT_W-1:0]  peak;
		logic [31:0]       mask;
		logic [31:0]       allocs;
		logic [31:0]       frees;
	} pool_rsp_t;

	// shadow pool state, indexed by pool (small, medium)
	logic [31:0]      small_base, medium_base;
	logic [5:0]       link_tbl [2][32];
	logic [5:0]       head     [2];
	logic [31:0]      mask     [2];
	logic [CNT_W-1:0] active   [2];
	logic [CNT_W-1:0] peak     [2];
	logic [31:0]      allocs   [2];
	logic [31:0]      frees    [2];

	pool_rsp_t expected_responses [$];
	pool_rsp_t oldest;
	int        err_count = 0;

	assign mismatches = err_count;

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		err_count++;
		$display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
	endtask

	task automatic compare_field(string what, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	task automatic reset_pools();
		for (int i = 0; i < 32; i++) begin
			link_tbl[POOL_SMALL][i]  = (i + 1 < SMALL_BLOCKS_DEF) ? 6'(i + 1) : 6'(SMALL_BLOCKS_DEF);
			link_tbl[POOL_MEDIUM][i] = (i + 1 < MEDIUM_BLOCKS_DEF) ? 6'(i + 1) : 6'(MEDIUM_BLOCKS_DEF);
		end
		for (int p = 0; p < 2; p++) begin
			head[p]   = '0;
			mask[p]   = '0;
			active[p] = '0;
			peak[p]   = '0;
			allocs[p] = '0;
			frees[p]  = '0;
		end
		small_base  = SMALL_BASE_RST;
		medium_base = MEDIUM_BASE_RST;
	endtask

	function automatic pool_rsp_t predict_response(tpba_kind_t k, logic [15:0] sz,
			logic [1:0] sel, logic [31:0] addr);
		pool_rsp_t   r;
		logic        touched;
		logic        p;
		logic        ok;
		logic [31:0] n, bytes, base, off, blk, h;
		r       = '0;
		touched = 1'b0;
		p       = POOL_SMALL;
		ok      = 1'b0;
		case (k)
		KIND_ALLOC_SIZE: begin
			if (sz != 0 && sz <= SMALL_BLOCK_BYTES_DEF) begin
				touched = 1'b1;
				p = POOL_SMALL;
			end else if (sz != 0 && sz <= MEDIUM_BLOCK_BYTES_DEF) begin
				touched = 1'b1;
				p = POOL_MEDIUM;
			end
		end
		KIND_ALLOC_POOL, KIND_STATS: begin
			if (sel == {1'b0, POOL_SMALL}) begin
				touched = 1'b1;
				p = POOL_SMALL;
			end else if (sel == {1'b0, POOL_MEDIUM}) begin
				touched = 1'b1;
				p = POOL_MEDIUM;
			end
		end
		default: begin
			// small pool claims the address first where the pools overlap
			if (addr != 0) begin
				if (addr - small_base < SMALL_SPAN) begin
					touched = 1'b1;
					p = POOL_SMALL;
				end else if (addr - medium_base < MEDIUM_SPAN) begin
					touched = 1'b1;
					p = POOL_MEDIUM;
				end
			end
		end
		endcase

		if (!touched) begin
			r.status = 1'b1;
			return r;
		end

		n     = (p == POOL_SMALL) ? SMALL_BLOCKS_DEF : MEDIUM_BLOCKS_DEF;
		bytes = (p == POOL_SMALL) ? SMALL_BLOCK_BYTES_DEF : MEDIUM_BLOCK_BYTES_DEF;
		base  = (p == POOL_SMALL) ? small_base : medium_base;

		case (k)
		KIND_ALLOC_SIZE, KIND_ALLOC_POOL: begin
			h = 32'(head[p]);
			if (h < n) begin
				head[p] = link_tbl[p][h[4:0]];
				mask[p][h[4:0]] = 1'b1;
				active[p]++;
				if (active[p] > peak[p])
					peak[p] = active[p];
				allocs[p]++;
				r.idx     = h[4:0];
				r.granted = base + h * bytes;
				ok = 1'b1;
			end
		end
		KIND_FREE: begin
			off = addr - base;
			if (off % bytes == 0) begin
				blk = off / bytes;
				if (blk < n && mask[p][blk[4:0]]) begin
					mask[p][blk[4:0]] = 1'b0;
					link_tbl[p][blk[4:0]] = head[p];
					head[p] = blk[5:0];
					if (active[p] != 0)
						active[p]--;
					frees[p]++;
					r.idx = blk[4:0];
					ok = 1'b1;
				end
			end
		end
		default: ok = 1'b1;
		endcase

		r.status = !ok;
		r.pool   = p;
		r.active = active[p];
		r.peak   = peak[p];
		r.mask   = mask[p];
		r.allocs = allocs[p];
		r.frees  = frees[p];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_pools();
			expected_responses.delete();
			outstanding <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_responses.size() == 0) begin
					report_mismatch("response with no request pending", '0, '0);
				end else begin
					oldest = expected_responses.pop_front();
					compare_field("status", 32'(status), 32'(oldest.status));
					compare_field("granted_address", granted_address, oldest.granted);
					compare_field("pool_used", 32'(pool_used), 32'(oldest.pool));
					compare_field("block_index", 32'(block_index), 32'(oldest.idx));
					compare_field("active_blocks", 32'(active_blocks), 32'(oldest.active));
					compare_field("peak_blocks", 32'(peak_blocks), 32'(oldest.peak));
					compare_field("allocated_bits", allocated_bits, oldest.mask);
					compare_field("alloc_total", alloc_total, oldest.allocs);
					compare_field("free_total", free_total, oldest.frees);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_SMALL_BASE:  small_base  = cfg_data;
				CFG_MEDIUM_BASE: medium_base = cfg_data;
				default: ;
				endcase
			end
			if (req_valid && req_ready)
				expected_responses.push_back(predict_response(tpba_kind_t'(kind),
					request_size, pool_select, block_address));
			outstanding <= expected_responses.size();
		end
	end

endmodule

// ===== dv/tb_two_pool_block_allocator_core.sv =====
module tb_two_pool_block_allocator_core;
	import tpba_pkg::*;

	// pool select codes as seen on the request port
	localparam logic [1:0] SEL_SMALL     = {1'b0, POOL_SMALL};
	localparam logic [1:0] SEL_MEDIUM    = {1'b0, POOL_MEDIUM};
	localparam logic [1:0] SEL_INVALID_A = 2'd2;
	localparam logic [1:0] SEL_INVALID_B = 2'd3;

	// an index the register map does not decode, written to show it is ignored
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_MEDIUM_BASE + 8'd1;

	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 260;
	localparam int CHUNK_ITEMS = 65;
	// long receiver hold-off, well past the two requests the block can buffer
	localparam int HOLD_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        req_valid;
	logic        req_ready;
	logic [1:0]  kind;
	logic [15:0] request_size;
	logic [1:0]  pool_select;
	logic [31:0] block_address;
	logic        rsp_valid;
	logic        rsp_ready;
	logic        status;
	logic [31:0] granted_address;
	logic        pool_used;
	logic [4:0]  block_index;
	logic [5:0]  active_blocks;
	logic [5:0]  peak_blocks;
	logic [31:0] allocated_bits;
	logic [31:0] alloc_total;
	logic [31:0] free_total;
	int          mismatches;
	int          outstanding;

	// bases currently programmed, used to aim frees at real blocks
	logic [31:0] small_base_now  = SMALL_BASE_RST;
	logic [31:0] medium_base_now = MEDIUM_BASE_RST;

	// quiet: no idling on either side; hold_rsp: receiver starts a long hold-off
	bit quiet    = 1'b0;
	bit hold_rsp = 1'b0;

	int alloc_bias [PHASES] = '{85, 35, 65, 90, 25, 60, 75};

	two_pool_block_allocator_core dut (.*);

	tpba_response_checker checker_i (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// mostly short gaps, now and then a long one
	function automatic int draw_gap();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	function automatic logic [31:0] block_addr(logic p, int idx);
		if (p == POOL_SMALL)
			return small_base_now + 32'(idx * SMALL_BLOCK_BYTES_DEF);
		return medium_base_now + 32'(idx * MEDIUM_BLOCK_BYTES_DEF);
	endfunction

	// valid stays high from one write to the next; the caller lowers it
	task automatic write_reg(logic [7:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic set_bases(logic [31:0] small_b, logic [31:0] medium_b);
		write_reg(CFG_SMALL_BASE, small_b);
		write_reg(CFG_MEDIUM_BASE, medium_b);
		write_reg(CFG_UNMAPPED, 32'($urandom));
		cfg_valid <= 1'b0;
		small_base_now  = small_b;
		medium_base_now = medium_b;
	endtask

	// optional idle gap, then hold the request until the block takes it
	task automatic send_request(tpba_kind_t k, logic [15:0] sz, logic [1:0] sel,
			logic [31:0] addr);
		if (!quiet && $urandom_range(0, 9) < 3) begin
			req_valid <= 1'b0;
			repeat (draw_gap()) @(posedge clk);
		end
		req_valid     <= 1'b1;
		kind          <= k;
		request_size  <= sz;
		pool_select   <= sel;
		block_address <= addr;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	// stop offering and wait for every pending response; the outstanding count is registered and lags
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// one random request; alloc_pct steers the pools toward full or empty
	task automatic issue_random(int alloc_pct);
		tpba_kind_t  k;
		logic [15:0] sz;
		logic [1:0]  sel;
		logic [31:0] addr;
		logic        p;
		int          step;
		int          roll;
		// unused fields carry random noise
		sz   = 16'($urandom);
		sel  = 2'($urandom);
		addr = 32'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < alloc_pct) begin
			if ($urandom_range(0, 1) == 1) begin
				k = KIND_ALLOC_SIZE;
				case ($urandom_range(0, 9))
				0: ;                   // full 16-bit range, mostly too big
				1: sz = '0;
				default: sz = 16'($urandom_range(1, MEDIUM_BLOCK_BYTES_DEF));
				endcase
			end else begin
				k = KIND_ALLOC_POOL;
				if ($urandom_range(0, 9) != 0)
					sel = 2'($urandom_range(0, 1));
			end
		end else if (roll < 92) begin
			k = KIND_FREE;
			p = 1'($urandom_range(0, 1));
			if (p == POOL_SMALL) begin
				addr = block_addr(p, $urandom_range(0, SMALL_BLOCKS_DEF - 1));
				step = SMALL_BLOCK_BYTES_DEF;
			end else begin
				addr = block_addr(p, $urandom_range(0, MEDIUM_BLOCKS_DEF - 1));
				step = MEDIUM_BLOCK_BYTES_DEF;
			end
			case ($urandom_range(0, 19))
			0: addr = '0;                                        // null
			1: addr = 32'($urandom);                             // likely outside both pools
			2: addr = addr + 32'($urandom_range(1, step - 1));   // misaligned
			default: ;                                           // block start
			endcase
		end else begin
			k = KIND_STATS;
			if ($urandom_range(0, 7) != 0)
				sel = 2'($urandom_range(0, 1));
		end
		send_request(k, sz, sel, addr);
	endtask

	// receiver: random stalls, quiet stretches, and the long hold-off on demand
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
				rsp_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) < 3) begin
				rsp_ready <= 1'b0;
				repeat (draw_gap()) @(posedge clk);
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// worst case is roughly 1850 requests times a long gap on each side plus
	// the hold-off; allow far more
	initial begin
		#15_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		req_valid     = 1'b0;
		kind          = '0;
		request_size  = '0;
		pool_select   = '0;
		block_address = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset bases, fresh pools
		send_request(KIND_STATS, '0, SEL_SMALL, '0);
		send_request(KIND_STATS, '0, SEL_MEDIUM, '0);
		send_request(KIND_STATS, '0, SEL_INVALID_A, '0);
		send_request(KIND_STATS, '0, SEL_INVALID_B, '0);
		// size boundaries: zero, small range, medium range, too big
		send_request(KIND_ALLOC_SIZE, 16'd0, SEL_SMALL, '0);
		send_request(KIND_ALLOC_SIZE, 16'd1, SEL_SMALL, '0);
		send_request(KIND_ALLOC_SIZE, 16'(SMALL_BLOCK_BYTES_DEF), SEL_SMALL, '0);
		send_request(KIND_ALLOC_SIZE, 16'(SMALL_BLOCK_BYTES_DEF + 1), SEL_SMALL, '0);
		send_request(KIND_ALLOC_SIZE, 16'(MEDIUM_BLOCK_BYTES_DEF), SEL_SMALL, '0);
		send_request(KIND_ALLOC_SIZE, 16'(MEDIUM_BLOCK_BYTES_DEF + 1), SEL_SMALL, '0);
		send_request(KIND_ALLOC_SIZE, 16'hFFFF, SEL_INVALID_B, 32'hFFFF_FFFF);
		// allocate by pool, valid and invalid selects
		send_request(KIND_ALLOC_POOL, '0, SEL_SMALL, '0);
		send_request(KIND_ALLOC_POOL, '0, SEL_MEDIUM, '0);
		send_request(KIND_ALLOC_POOL, '0, SEL_INVALID_A, '0);
		send_request(KIND_ALLOC_POOL, 16'hFFFF, SEL_INVALID_B, '0);
		// frees: null, outside, misaligned, never allocated, good, double free
		send_request(KIND_FREE, '0, SEL_SMALL, '0);
		send_request(KIND_FREE, '0, SEL_SMALL, 32'hFFFF_FFFF);
		send_request(KIND_FREE, '0, SEL_SMALL, block_addr(POOL_SMALL, 0) + 32'd1);
		send_request(KIND_FREE, '0, SEL_SMALL, block_addr(POOL_SMALL, SMALL_BLOCKS_DEF - 1));
		send_request(KIND_FREE, '0, SEL_SMALL, block_addr(POOL_SMALL, 0));
		send_request(KIND_FREE, '0, SEL_SMALL, block_addr(POOL_SMALL, 0));
		send_request(KIND_FREE, '0, SEL_MEDIUM,
			block_addr(POOL_MEDIUM, 0) + 32'(MEDIUM_BLOCK_BYTES_DEF / 2));
		send_request(KIND_FREE, '0, SEL_MEDIUM, block_addr(POOL_MEDIUM, 0));
		send_request(KIND_FREE, '0, SEL_MEDIUM, block_addr(POOL_MEDIUM, MEDIUM_BLOCKS_DEF - 1));
		send_request(KIND_STATS, '0, SEL_SMALL, '0);
		drain();

		// random phases, each under its own pair of bases and alloc/free mix
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
			1: set_bases(32'd1, 32'hFFFF_FFFF);                 // lowest and highest bases
			2: set_bases(32'hFFFF_FFC0, 32'h0001_0000);         // small wraps, one block at zero
			3: set_bases(32'h0002_0000, 32'h0002_0400);         // medium overlaps top half of small
			4: set_bases(32'($urandom_range(1, 32'hFFFF_FFFF)),
				32'($urandom_range(1, 32'hFFFF_FFFF)));
			5: set_bases(32'($urandom) | 32'h0000_0040, 32'($urandom) & ~32'hFF | 32'h100);
			6: set_bases(32'h8000_0000, 32'h7FFF_F000);         // medium ends where small starts
			default: ;
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % CHUNK_ITEMS == 0)
					quiet = ($urandom_range(0, 3) == 0);
				// back-to-back requests against a stalled receiver fill the block
				if (ph == 1 && i == 0) begin
					quiet    = 1'b1;
					hold_rsp = 1'b1;
				end
				issue_random(alloc_bias[ph]);
			end
			// sender pauses until every response is back, then bases may change
			drain();
		end

		quiet = 1'b0;
		// a few more edges to catch a stray response
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/tpba_pkg.sv
src/tpba_link_mem.sv
src/tpba_pool.sv
src/tpba_decode.sv
src/two_pool_block_allocator_core.sv
dv/tpba_response_checker.sv
dv/tb_two_pool_block_allocator_core.sv
